[hdl/bilinear_image_resampler_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear image resampler
// Short forms for clocked assertions, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_RESAMPLER_CORE_MACROS_SVH
`define BILINEAR_IMAGE_RESAMPLER_CORE_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define BIR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bir assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define BIR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bir assertion failed");

// Condition holds at every clock edge out of reset.
`define BIR_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bir assertion failed");

`endif

[hdl/bir_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler package
// Sizes, pixel and bank types, and the request structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

	localparam int MAX_SOURCE_WIDTH  = 256;
	localparam int MAX_SOURCE_HEIGHT = 256;
	localparam int FRACTION_BITS     = 16;

	localparam int COORD_W = 12;
	localparam int STEP_W  = 24;
	localparam int SIZE_W  = 9;
	localparam int CHAN_W  = 8;
	localparam int PIX_W   = 4 * CHAN_W;

	localparam int COL_W   = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
	localparam int ROW_W   = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
	localparam int BCOL_W  = (COL_W > 1) ? COL_W - 1 : 1;
	localparam int BROW_W  = (ROW_W > 1) ? ROW_W - 1 : 1;
	localparam int BANK_AW = BCOL_W + BROW_W;
	localparam int BANK_DEPTH = 2 ** BANK_AW;

	localparam int POS_W   = COORD_W + STEP_W;
	localparam int WHOLE_W = POS_W - FRACTION_BITS;

	typedef logic [COL_W-1:0]         col_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [FRACTION_BITS-1:0] frac_t;
	typedef logic [PIX_W-1:0]         pixel_t;
	typedef logic [BANK_AW-1:0]       bank_addr_t;

	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	// Store write of one loaded pixel.
	typedef struct packed {
		logic   en;
		col_t   col;
		row_t   row;
		pixel_t data;
	} wr_req_t;

	// Store read of the four neighbours of one sample.
	typedef struct packed {
		logic en;
		col_t col_near;
		col_t col_far;
		row_t row_near;
		row_t row_far;
	} rd_req_t;

	// The four neighbours: first digit row (near, far), second digit column.
	typedef struct packed {
		pixel_t p00;
		pixel_t p01;
		pixel_t p10;
		pixel_t p11;
	} quad_t;

	// Last usable index for a size register, the size saturated to 1..max_size.
	function automatic int last_index(input logic [SIZE_W-1:0] size, input int max_size);
		int s;
		s = int'(size);
		if (s < 1) s = 1;
		if (s > max_size) s = max_size;
		return s - 1;
	endfunction

endpackage

`default_nettype wire

[hdl/bir_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// A read at the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hdl/bir_store.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler source store
// Four parity banks of the source image, so all four neighbours read at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_store (
	input  logic             clk,
	input  bir_pkg::wr_req_t wr,
	input  bir_pkg::rd_req_t rd,
	output bir_pkg::quad_t   quad
);

	import bir_pkg::*;

	function automatic bank_addr_t bank_addr(input col_t c, input row_t r);
		return {BROW_W'(r >> 1), BCOL_W'(c >> 1)};
	endfunction

	pixel_t bank_data [4];
	logic   col_near_par_q, col_far_par_q, row_near_par_q, row_far_par_q;

	// Bank index is {row parity, column parity}.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic CP = 1'(b % 2);
		localparam logic RP = 1'(b / 2);

		col_t rd_col;
		row_t rd_row;
		logic bank_wr_en;

		assign rd_col     = (rd.col_near[0] == CP) ? rd.col_near : rd.col_far;
		assign rd_row     = (rd.row_near[0] == RP) ? rd.row_near : rd.row_far;
		assign bank_wr_en = wr.en && (wr.col[0] == CP) && (wr.row[0] == RP);

		bir_ram #(
			.WIDTH (PIX_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (bank_wr_en),
			.wr_addr (bank_addr(wr.col, wr.row)),
			.wr_data (wr.data),
			.rd_en   (rd.en),
			.rd_addr (bank_addr(rd_col, rd_row)),
			.rd_data (bank_data[b])
		);
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			col_near_par_q <= rd.col_near[0];
			col_far_par_q  <= rd.col_far[0];
			row_near_par_q <= rd.row_near[0];
			row_far_par_q  <= rd.row_far[0];
		end
	end

	assign quad.p00 = bank_data[{row_near_par_q, col_near_par_q}];
	assign quad.p01 = bank_data[{row_near_par_q, col_far_par_q}];
	assign quad.p10 = bank_data[{row_far_par_q, col_near_par_q}];
	assign quad.p11 = bank_data[{row_far_par_q, col_far_par_q}];

endmodule

`default_nettype wire

[hdl/bir_blend.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler channel blend
// Blends two RGBA pixels by a fraction, each channel rounded half up.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_blend (
	input  bir_pkg::pixel_t a,
	input  bir_pkg::pixel_t b,
	input  bir_pkg::frac_t  t,
	output bir_pkg::pixel_t y
);

	import bir_pkg::*;

	localparam int BW = CHAN_W + FRACTION_BITS + 1;
	localparam logic [FRACTION_BITS:0] ONE  = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;
	localparam logic [BW-1:0]          HALF = BW'(1) << (FRACTION_BITS - 1);

	function automatic logic [CHAN_W-1:0] blend_chan(
		input logic [CHAN_W-1:0] ca,
		input logic [CHAN_W-1:0] cb,
		input frac_t             tf
	);
		logic [FRACTION_BITS:0] wa;
		logic [BW-1:0]          s;
		wa = ONE - {1'b0, tf};
		s  = BW'(ca) * BW'(wa) + BW'(cb) * BW'(tf) + HALF;
		return s[FRACTION_BITS +: CHAN_W];
	endfunction

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			y[ch*CHAN_W +: CHAN_W] = blend_chan(a[ch*CHAN_W +: CHAN_W],
				b[ch*CHAN_W +: CHAN_W], t);
		end
	end

endmodule

`default_nettype wire

[hdl/bilinear_image_resampler_core.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler core
// Holds an RGBA8888 source image and answers destination pixel samples with
// bilinearly interpolated pixels.
// ----------------------------------------------------------------------------
//
// Channel   Bus          Beat content
// --------  -----------  -----------------------------------------------
// input     s_axis       load a source pixel or sample a destination one
// output    m_axis       one interpolated pixel for each sample beat
// config    APB          source size and per-axis step registers
//
// One beat is taken every cycle unless a stalled output has backed up the pipeline.
// A sample beat passes through the input register, position multiply, bank read,
// horizontal blend, then vertical blend into the output register. The banked
// store sets the rate: one read of all four neighbours per cycle.
// Reset empties the pipeline and resets the registers; the image itself is undefined
// until loaded and no clearing pass runs. A stalled output holds its beat while
// empty stages upstream keep taking input; load beats leave no result.
//
`default_nettype none

module bilinear_image_resampler_core (
	input  logic        clk,
	input  logic        arst_n,

	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata from bit 0 up: coord_x[11:0], coord_y[11:0], red_in[7:0],
	// green_in[7:0], blue_in[7:0], alpha_in[7:0].
	input  logic [55:0] s_axis_tdata,
	// tuser: kind (0 load, 1 sample).
	input  logic        s_axis_tuser,

	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata from bit 0 up: red_out[7:0], green_out[7:0], blue_out[7:0],
	// alpha_out[7:0].
	output logic [31:0] m_axis_tdata,

	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import bir_pkg::*;

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_STEP_H        = 2'd2,
		REG_STEP_V        = 2'd3
	} reg_idx_t;

	// ------------------------------------------------------------------
	// Configuration registers. The port has no wait states.
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0] source_width_q, source_height_q;
	logic [STEP_W-1:0] step_h_q, step_v_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= SIZE_W'(256);
			source_height_q <= SIZE_W'(256);
			step_h_q        <= '0;
			step_v_q        <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SOURCE_WIDTH:  source_width_q  <= pwdata[SIZE_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= pwdata[SIZE_W-1:0];
				REG_STEP_H:        step_h_q        <= pwdata[STEP_W-1:0];
				REG_STEP_V:        step_v_q        <= pwdata[STEP_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_SOURCE_WIDTH:  prdata = 32'(source_width_q);
			REG_SOURCE_HEIGHT: prdata = 32'(source_height_q);
			REG_STEP_H:        prdata = 32'(step_h_q);
			REG_STEP_V:        prdata = 32'(step_v_q);
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow. Each stage moves on when the stage after it is empty
	// or moving, so bubbles close up behind a stalled output.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !out_valid_q || m_axis_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign s_axis_tready = rdy1;

	// Stage 1: the accepted beat.
	kind_t              kind_s1;
	logic [COORD_W-1:0] cx_s1, cy_s1;
	pixel_t             pix_s1;

	// Stage 2: the exact source positions of a sample.
	logic [POS_W-1:0]   pos_x_s2, pos_y_s2;

	// Stage 3: fractions, aligned with the bank read data.
	frac_t              fx_s3, fy_s3;

	// Stage 4: the two horizontal blends.
	pixel_t             top_s4, bot_s4;
	frac_t              fy_s4;

	pixel_t             out_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			// A load ends in stage 1, where its pixel is written if it is in range.
			if (rdy2) v_s2 <= v_s1 && (kind_s1 == KIND_SAMPLE);
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1 <= kind_t'(s_axis_tuser);
			cx_s1   <= s_axis_tdata[11:0];
			cy_s1   <= s_axis_tdata[23:12];
			pix_s1  <= s_axis_tdata[55:24];
		end
		if (rdy2) begin
			pos_x_s2 <= POS_W'(cx_s1) * POS_W'(step_h_q);
			pos_y_s2 <= POS_W'(cy_s1) * POS_W'(step_v_q);
		end
	end

	// ------------------------------------------------------------------
	// Load: write the pixel as the beat leaves stage 1. A sample behind it
	// reads later, in stage 2, and sees the new word; a sample ahead of it
	// reads in the same cycle or earlier and gets the old one.
	// ------------------------------------------------------------------
	wr_req_t wr;
	logic    load_in_range;

	assign load_in_range = ({1'b0, cx_s1} < (COORD_W + 1)'(MAX_SOURCE_WIDTH)) &&
		({1'b0, cy_s1} < (COORD_W + 1)'(MAX_SOURCE_HEIGHT));

	assign wr.en   = v_s1 && (kind_s1 == KIND_LOAD) && rdy2 && load_in_range;
	assign wr.col  = cx_s1[COL_W-1:0];
	assign wr.row  = cy_s1[ROW_W-1:0];
	assign wr.data = pix_s1;

	// ------------------------------------------------------------------
	// Stage 2: neighbour indices. A near index at or past the last column
	// (row) puts both neighbours on that last column (row).
	// ------------------------------------------------------------------
	col_t               last_x, near_x;
	row_t               last_y, near_y;
	logic [WHOLE_W-1:0] whole_x, whole_y;
	logic               past_x, past_y;
	rd_req_t            rd;

	assign last_x  = COL_W'(last_index(source_width_q, MAX_SOURCE_WIDTH));
	assign last_y  = ROW_W'(last_index(source_height_q, MAX_SOURCE_HEIGHT));
	assign whole_x = pos_x_s2[POS_W-1:FRACTION_BITS];
	assign whole_y = pos_y_s2[POS_W-1:FRACTION_BITS];
	assign past_x  = whole_x >= WHOLE_W'(last_x);
	assign past_y  = whole_y >= WHOLE_W'(last_y);
	assign near_x  = past_x ? last_x : whole_x[COL_W-1:0];
	assign near_y  = past_y ? last_y : whole_y[ROW_W-1:0];

	assign rd.en       = rdy3;
	assign rd.col_near = near_x;
	assign rd.col_far  = past_x ? last_x : near_x + col_t'(1);
	assign rd.row_near = near_y;
	assign rd.row_far  = past_y ? last_y : near_y + row_t'(1);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			fx_s3 <= pos_x_s2[FRACTION_BITS-1:0];
			fy_s3 <= pos_y_s2[FRACTION_BITS-1:0];
		end
	end

	quad_t quad;

	bir_store u_store (
		.clk  (clk),
		.wr   (wr),
		.rd   (rd),
		.quad (quad)
	);

	// ------------------------------------------------------------------
	// Stage 3: blend along each row by the column fraction.
	// Stage 4: blend the two row results by the row fraction.
	// ------------------------------------------------------------------
	pixel_t top_pix, bot_pix, out_pix;

	bir_blend u_blend_top (
		.a (quad.p00),
		.b (quad.p01),
		.t (fx_s3),
		.y (top_pix)
	);

	bir_blend u_blend_bot (
		.a (quad.p10),
		.b (quad.p11),
		.t (fx_s3),
		.y (bot_pix)
	);

	bir_blend u_blend_vert (
		.a (top_s4),
		.b (bot_s4),
		.t (fy_s4),
		.y (out_pix)
	);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			top_s4 <= top_pix;
			bot_s4 <= bot_pix;
			fy_s4  <= fy_s3;
		end
		if (rdy5) begin
			out_pix_q <= out_pix;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pix_q;

endmodule

`default_nettype wire

[hdl/bir_checker.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler port checker
// Watches the stream ports: output holding and sample-to-pixel accounting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_image_resampler_core_macros.svh"

module bir_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	import bir_pkg::*;

	// Five stages can hold a sample at once.
	localparam logic [2:0] PEND_MAX = 3'd5;

	logic [2:0] pending_q;
	logic       smp_beat, out_beat;

	assign smp_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_SAMPLE);
	assign out_beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(smp_beat) - 3'(out_beat);
		end
	end

	`BIR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`BIR_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`BIR_ASSERT_IMPL(a_no_orphan, pending_q == 3'd0, !m_axis_tvalid)
	`BIR_ASSERT_ALWAYS(a_depth, pending_q <= PEND_MAX)

endmodule

bind bilinear_image_resampler_core bir_checker u_bir_checker (.*);

`default_nettype wire

[test/resampler_tb_pkg.sv]
// ----------------------------------------------------------------------------
// Resampler testbench register map
// Byte addresses of the configuration registers, shared by the stimulus and
// the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package resampler_tb_pkg;

	typedef enum logic [3:0] {
		REG_SOURCE_WIDTH    = 4'h0,
		REG_SOURCE_HEIGHT   = 4'h4,
		REG_STEP_HORIZONTAL = 4'h8,
		REG_STEP_VERTICAL   = 4'hC
	} reg_addr_t;

endpackage

`default_nettype wire

[test/resampler_checker.sv]
// ----------------------------------------------------------------------------
// Resampler checker
// Watches the input, output and register channels of the resampler, keeps a
// shadow of the image and the registers, predicts every sampled pixel and
// compares the output beats against the predictions in order.
// ----------------------------------------------------------------------------
`default_nettype none

module resampler_checker
	import bir_pkg::*;
	import resampler_tb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	// tdata from bit 0 up: coord_x, coord_y, red, green, blue, alpha.
	input  wire logic [55:0] s_axis_tdata,
	// tuser: kind.
	input  wire logic        s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata from bit 0 up: red, green, blue, alpha.
	input  wire logic [31:0] m_axis_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               mismatches,
	output int               pending
);

	localparam int MAX_PRINTED = 100;

	pixel_t            image_shadow [MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT];
	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	logic [STEP_W-1:0] step_x_reg;
	logic [STEP_W-1:0] step_y_reg;
	pixel_t            pixels_due [$];

	initial mismatches = 0;
	initial pending = 0;

	function automatic int clamp_last(input logic [SIZE_W-1:0] size, input int limit);
		int s;
		s = int'(size);
		if (s < 1) s = 1;
		if (s > limit) s = limit;
		return s - 1;
	endfunction

	// Near and far neighbour on one axis, plus the blend fraction. A position
	// at or past the last index pins both neighbours to the last index.
	function automatic void locate(input logic [COORD_W-1:0] coord,
			input logic [STEP_W-1:0] step, input int last,
			output int near_idx, output int far_idx, output frac_t frac);
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] whole;
		pos = POS_W'(coord) * POS_W'(step);
		whole = pos >> FRACTION_BITS;
		frac = pos[FRACTION_BITS-1:0];
		if (whole >= POS_W'(last)) begin
			near_idx = last;
			far_idx = last;
		end else begin
			near_idx = int'(whole);
			far_idx = int'(whole) + 1;
		end
	endfunction

	// One linear blend with round half up.
	function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b, input frac_t t);
		logic [31:0] sum;
		sum = 32'(a) * ((32'd1 << FRACTION_BITS) - 32'(t)) + 32'(b) * 32'(t)
			+ (32'd1 << (FRACTION_BITS - 1));
		return sum[FRACTION_BITS +: CHAN_W];
	endfunction

	function automatic pixel_t interpolate_pixel(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		int                col0, col1, row0, row1, ch;
		frac_t             fx, fy;
		pixel_t            p00, p01, p10, p11, res;
		logic [CHAN_W-1:0] upper_mix, lower_mix;
		locate(x, step_x_reg, clamp_last(width_reg, MAX_SOURCE_WIDTH), col0, col1, fx);
		locate(y, step_y_reg, clamp_last(height_reg, MAX_SOURCE_HEIGHT), row0, row1, fy);
		p00 = image_shadow[row0 * MAX_SOURCE_WIDTH + col0];
		p01 = image_shadow[row0 * MAX_SOURCE_WIDTH + col1];
		p10 = image_shadow[row1 * MAX_SOURCE_WIDTH + col0];
		p11 = image_shadow[row1 * MAX_SOURCE_WIDTH + col1];
		res = '0;
		for (ch = 0; ch < 4; ch++) begin
			upper_mix = blend_channel(p00[ch*CHAN_W +: CHAN_W], p01[ch*CHAN_W +: CHAN_W], fx);
			lower_mix = blend_channel(p10[ch*CHAN_W +: CHAN_W], p11[ch*CHAN_W +: CHAN_W], fx);
			res[ch*CHAN_W +: CHAN_W] = blend_channel(upper_mix, lower_mix, fy);
		end
		return res;
	endfunction

	function automatic string channel_name(input int ch);
		case (ch)
			0: return "red";
			1: return "green";
			2: return "blue";
			default: return "alpha";
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTED)
			$display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t            want;
		logic [COORD_W-1:0] cx, cy;
		int                ch;
		if (!arst_n) begin
			width_reg = SIZE_W'(MAX_SOURCE_WIDTH);
			height_reg = SIZE_W'(MAX_SOURCE_HEIGHT);
			step_x_reg = '0;
			step_y_reg = '0;
			pixels_due.delete();
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pixels_due.size() == 0) begin
					report_mismatch("pixel with no sample waiting", m_axis_tdata, '0);
				end else begin
					want = pixels_due.pop_front();
					for (ch = 0; ch < 4; ch++)
						if (m_axis_tdata[ch*CHAN_W +: CHAN_W] != want[ch*CHAN_W +: CHAN_W])
							report_mismatch({channel_name(ch), " channel"},
								m_axis_tdata[ch*CHAN_W +: CHAN_W],
								want[ch*CHAN_W +: CHAN_W]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cx = s_axis_tdata[COORD_W-1:0];
				cy = s_axis_tdata[2*COORD_W-1:COORD_W];
				if (kind_t'(s_axis_tuser) == KIND_SAMPLE)
					pixels_due.push_back(interpolate_pixel(cx, cy));
				else if (cx < MAX_SOURCE_WIDTH && cy < MAX_SOURCE_HEIGHT)
					image_shadow[int'(cy) * MAX_SOURCE_WIDTH + int'(cx)] =
						s_axis_tdata[2*COORD_W +: PIX_W];
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_addr_t'(paddr))
					REG_SOURCE_WIDTH:    width_reg = pwdata[SIZE_W-1:0];
					REG_SOURCE_HEIGHT:   height_reg = pwdata[SIZE_W-1:0];
					REG_STEP_HORIZONTAL: step_x_reg = pwdata[STEP_W-1:0];
					REG_STEP_VERTICAL:   step_y_reg = pwdata[STEP_W-1:0];
					default: ;
				endcase
			end
			pending = pixels_due.size();
		end
	end

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler testbench
// Drives load and sample beats and register writes into the resampler core,
// with random gaps on both streams, and leaves the checking of every output
// pixel to the checker instantiated beside the core.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import bir_pkg::*;
	import resampler_tb_pkg::*;

	// The receiver hold-off is long enough to fill the pipeline many times over.
	localparam int HOLD_CYCLES     = 400;
	// No beat accepted anywhere for this many cycles means the core is hung.
	localparam int IDLE_LIMIT      = 4000;
	localparam int PHASES          = 10;
	// Input beats per random phase, loads of missing neighbours included.
	localparam int PHASE_BEATS     = 180;
	localparam int PRESSURE_BEATS  = 40;
	// Long enough for any trailing beat to leave the pipeline.
	localparam int DRAIN_CYCLES    = 12;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// tdata from bit 0 up: coord_x[11:0], coord_y[11:0], red[7:0], green[7:0],
	// blue[7:0], alpha[7:0].
	logic [55:0] s_axis_tdata = '0;
	// tuser: kind (load or sample).
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tdata from bit 0 up: red[7:0], green[7:0], blue[7:0], alpha[7:0].
	logic [31:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;

	// Calm turns off the random gaps on both sides for a stretch. A hold-off
	// request asks the receiver to stall for HOLD_CYCLES in a row.
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int run_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	// Store entries loaded so far; a sample only goes out once all four of
	// its neighbours are among them.
	bit                loaded [MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT];
	int                beats_sent = 0;
	// Register values in force, used to work out which entries a sample reads.
	int                cur_width = MAX_SOURCE_WIDTH;
	int                cur_height = MAX_SOURCE_HEIGHT;
	logic [STEP_W-1:0] cur_step_x = '0;
	logic [STEP_W-1:0] cur_step_y = '0;

	bilinear_image_resampler_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	resampler_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Gap length for either side: usually none or a few cycles, now and then
	// a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver: bursts of ready separated by random stalls. A hold-off request
	// takes priority and keeps ready low for HOLD_CYCLES counted here, while
	// the sender keeps offering beats so the core backs up into its input.
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (run_left > 0) begin
				run_left--;
			end else begin
				run_left = $urandom_range(0, 30);
				stall_left = calm ? 0 : pick_gap();
			end
		end
	end

	// Watchdog: any accepted beat on either stream or the register port
	// restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offers one input beat after an optional gap and returns at the falling
	// edge after it was accepted, so the next beat can follow with no bubble.
	task automatic send_beat(input kind_t kind, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input pixel_t px);
		int gap;
		beats_sent++;
		if (kind == KIND_LOAD && x < MAX_SOURCE_WIDTH && y < MAX_SOURCE_HEIGHT)
			loaded[int'(y) * MAX_SOURCE_WIDTH + int'(x)] = 1'b1;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {px, y, x};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Near and far index on one axis, worked out the way the core does it.
	function automatic void axis_span(input logic [COORD_W-1:0] coord,
			input logic [STEP_W-1:0] step, input int size_reg, input int max_size,
			output int near_idx, output int far_idx);
		longint whole;
		int     last;
		last = size_reg;
		if (last < 1) last = 1;
		if (last > max_size) last = max_size;
		last = last - 1;
		whole = (longint'(coord) * longint'(step)) >> FRACTION_BITS;
		if (whole >= longint'(last)) begin
			near_idx = last;
			far_idx = last;
		end else begin
			near_idx = int'(whole);
			far_idx = near_idx + 1;
		end
	endfunction

	// Loads any neighbour of the sample that is still unwritten, then sends
	// the sample itself.
	task automatic send_sample(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int cols [2];
		int rows [2];
		int a, b;
		axis_span(x, cur_step_x, cur_width, MAX_SOURCE_WIDTH, cols[0], cols[1]);
		axis_span(y, cur_step_y, cur_height, MAX_SOURCE_HEIGHT, rows[0], rows[1]);
		for (a = 0; a < 2; a++)
			for (b = 0; b < 2; b++)
				if (!loaded[rows[a] * MAX_SOURCE_WIDTH + cols[b]])
					send_beat(KIND_LOAD, COORD_W'(cols[b]), COORD_W'(rows[a]),
						pixel_t'($urandom()));
		send_beat(KIND_SAMPLE, x, y, pixel_t'($urandom()));
	endtask

	// Setup cycle, access cycle, then one idle cycle so that back-to-back
	// writes never drive psel twice in one step.
	task automatic apb_write(input reg_addr_t addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Registers change only with the core idle: every predicted pixel is out
	// and trailing load beats have had time to leave the pipeline.
	task automatic set_config(input int width, input int height,
			input logic [STEP_W-1:0] step_x, input logic [STEP_W-1:0] step_y);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		apb_write(REG_SOURCE_WIDTH, 32'(width));
		apb_write(REG_SOURCE_HEIGHT, 32'(height));
		apb_write(REG_STEP_HORIZONTAL, 32'(step_x));
		apb_write(REG_STEP_VERTICAL, 32'(step_y));
		cur_width = width;
		cur_height = height;
		cur_step_x = step_x;
		cur_step_y = step_y;
	endtask

	// Step as software would set it: (source - 1.01) / (dest - 1) in Q8.16,
	// with the source size taken as the core clamps it.
	function automatic logic [STEP_W-1:0] scale_step(input int size_reg, input int dest);
		int eff;
		eff = size_reg;
		if (eff < 1) eff = 1;
		if (eff > MAX_SOURCE_WIDTH) eff = MAX_SOURCE_WIDTH;
		if (dest < 2 || eff < 2) return '0;
		return STEP_W'((longint'(eff * 100 - 101) << FRACTION_BITS) / longint'(100 * (dest - 1)));
	endfunction

	function automatic int pick_dest();
		return ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 640);
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input int dest);
		if ($urandom_range(0, 9) == 0) return COORD_W'($urandom_range(0, 4095));
		return COORD_W'($urandom_range(0, dest - 1));
	endfunction

	initial begin : stimulus
		int                width, height, dest_x, dest_y, mode, r, i, p, start;
		logic [STEP_W-1:0] step_x, step_y;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on a 2x2 image: the four corners carry channel
		// extremes, so half-way positions check rounding half up.
		set_config(2, 2, 24'h010000, 24'h008000);
		send_beat(KIND_LOAD, 12'd0, 12'd0, 32'h0000_0000);
		send_beat(KIND_LOAD, 12'd1, 12'd0, 32'hFFFF_FFFF);
		send_beat(KIND_LOAD, 12'd0, 12'd1, 32'hFF00_FF00);
		send_beat(KIND_LOAD, 12'd1, 12'd1, 32'h00FF_00FF);
		// Loads outside the store are dropped; the corners above must survive.
		send_beat(KIND_LOAD, 12'd256, 12'd0, 32'h1234_5678);
		send_beat(KIND_LOAD, 12'd0, 12'd256, 32'h8765_4321);
		send_beat(KIND_LOAD, 12'd4095, 12'd4095, 32'hA5A5_A5A5);
		send_beat(KIND_SAMPLE, 12'd0, 12'd0, 32'h0000_0000);
		send_beat(KIND_SAMPLE, 12'd0, 12'd1, 32'hFFFF_FFFF);
		send_beat(KIND_SAMPLE, 12'd1, 12'd0, 32'h0000_0000);
		send_beat(KIND_SAMPLE, 12'd1, 12'd1, 32'hFFFF_FFFF);
		// Positions far past the last column and row clamp both neighbours.
		send_beat(KIND_SAMPLE, 12'd4095, 12'd4095, 32'h0000_0000);
		// Largest step against the smallest nonzero one.
		set_config(2, 2, 24'hFFFFFF, 24'h000001);
		send_beat(KIND_SAMPLE, 12'd1, 12'd4095, 32'h0000_0000);
		send_beat(KIND_SAMPLE, 12'd4095, 12'd2048, 32'h0000_0000);
		send_beat(KIND_SAMPLE, 12'd0, 12'd1, 32'h0000_0000);

		// Back-pressure: the receiver stalls for a long stretch while samples
		// keep coming, so the core must stop taking input and lose nothing.
		dest_x = pick_dest();
		dest_y = pick_dest();
		set_config(MAX_SOURCE_WIDTH, MAX_SOURCE_HEIGHT,
			scale_step(MAX_SOURCE_WIDTH, dest_x), scale_step(MAX_SOURCE_HEIGHT, dest_y));
		calm = 1'b1;
		hold_req = 1'b1;
		for (i = 0; i < PRESSURE_BEATS; i++)
			send_sample(pick_coord(dest_x), pick_coord(dest_y));
		calm = 1'b0;

		// Random phases: the first few pin the size registers to their
		// extremes, including values the core has to saturate.
		for (p = 0; p < PHASES; p++) begin
			dest_x = pick_dest();
			dest_y = pick_dest();
			case (p)
				0: begin
					width = MAX_SOURCE_WIDTH;
					height = MAX_SOURCE_HEIGHT;
				end
				1: begin
					width = 2;
					height = 2;
				end
				2: begin
					width = 0;
					height = 511;
				end
				3: begin
					width = 1;
					height = 300;
				end
				default: begin
					width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
						: $urandom_range(2, MAX_SOURCE_WIDTH);
					height = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
						: $urandom_range(2, MAX_SOURCE_HEIGHT);
				end
			endcase
			mode = (p == 0) ? 9 : (p == 1) ? 1 : $urandom_range(0, 9);
			case (mode)
				0: begin
					step_x = '0;
					step_y = '0;
				end
				1: begin
					step_x = 24'hFFFFFF;
					step_y = '0;
				end
				2: begin
					step_x = STEP_W'($urandom());
					step_y = STEP_W'($urandom());
				end
				default: begin
					step_x = scale_step(width, dest_x);
					step_y = scale_step(height, dest_y);
				end
			endcase
			set_config(width, height, step_x, step_y);
			calm = ($urandom_range(0, 3) == 0);

			// Mostly samples over the destination grid, some reloads of the
			// image and a few loads with random coordinates.
			start = beats_sent;
			while (beats_sent - start < PHASE_BEATS) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					send_sample(pick_coord(dest_x), pick_coord(dest_y));
				else if (r < 95)
					send_beat(KIND_LOAD, COORD_W'($urandom_range(0, MAX_SOURCE_WIDTH - 1)),
						COORD_W'($urandom_range(0, MAX_SOURCE_HEIGHT - 1)),
						pixel_t'($urandom()));
				else
					send_beat(KIND_LOAD, COORD_W'($urandom_range(0, 4095)),
						COORD_W'($urandom_range(0, 4095)), pixel_t'($urandom()));
			end
			calm = 1'b0;
		end

		// Drain: every predicted pixel must arrive, and nothing may follow.
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/bir_pkg.sv
hdl/bir_ram.sv
hdl/bir_store.sv
hdl/bir_blend.sv
hdl/bilinear_image_resampler_core.sv
hdl/bir_checker.sv
test/resampler_tb_pkg.sv
test/resampler_checker.sv
test/testbench.sv
